/* hdl/crt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg: shared types and codes of the chunk reassembly tracker
// Action, status, command-kind and register codes, limit reset values, queue
// geometry, and the command word that travels from the classifier to the context engine.
// ----------------------------------------------------------------------------
package crt_pkg;

   // action codes on the request side
   localparam logic [1:0] ACT_CHUNK = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_FLUSH = 2'd2;

   // status codes on the response side
   localparam logic [2:0] ST_CLEARED  = 3'd0;
   localparam logic [2:0] ST_PARTIAL  = 3'd1;
   localparam logic [2:0] ST_COMPLETE = 3'd2;
   localparam logic [2:0] ST_BADHDR   = 3'd3;
   localparam logic [2:0] ST_ORDER    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;
   localparam logic [2:0] ST_MISMATCH = 3'd6;

   // register indexes
   localparam logic [1:0] REG_MAX_TOTAL = 2'd0;
   localparam logic [1:0] REG_MAX_COUNT = 2'd1;
   localparam logic [1:0] REG_MAX_BYTES = 2'd2;

   // limit reset values
   localparam logic [23:0] MAX_TOTAL_RST = 24'd1048576;
   localparam logic [15:0] MAX_COUNT_RST = 16'd256;
   localparam logic [14:0] MAX_BYTES_RST = 15'd8000;

   // command kinds after classification
   localparam logic [2:0] K_CHUNK = 3'd0;   // header passed every check
   localparam logic [2:0] K_BAD   = 3'd1;   // rejected header or unused action
   localparam logic [2:0] K_CLEAR = 3'd2;   // clear one sender
   localparam logic [2:0] K_FLUSH = 3'd3;   // clear all senders
   localparam logic [2:0] K_NOP   = 3'd4;   // clear of a sender that does not exist

   // command queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  sender;
      logic [23:0] total;
      logic [15:0] index;
      logic [15:0] count;
      logic [14:0] length;
   } crt_cmd_type;

endpackage

/* hdl/crt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_front: request classifier
// Holds the limit registers, checks each header against them and turns the
// request word into a narrow command for the context engine.
// ----------------------------------------------------------------------------
module crt_front #(
   parameter int SENDERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [23:0]        csr_wdata,
   input  logic [1:0]         action,
   input  logic [3:0]         sender,
   input  logic [31:0]        declared_total,
   input  logic [31:0]        chunk_index,
   input  logic [31:0]        chunk_count,
   input  logic [31:0]        chunk_length,
   input  logic [14:0]        bytes_left,
   input  logic               header_bad,
   output crt_pkg::crt_cmd_type cmd
);
   import crt_pkg::*;

   logic [23:0] max_total_ff;
   logic [15:0] max_count_ff;
   logic [14:0] max_bytes_ff;
   logic        sender_ok;
   logic        total_ok;
   logic        count_ok;
   logic        index_ok;
   logic        length_ok;
   logic        header_ok;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= MAX_TOTAL_RST;
         max_count_ff <= MAX_COUNT_RST;
         max_bytes_ff <= MAX_BYTES_RST;
      end else if (csr_we) begin
         if (csr_addr == REG_MAX_TOTAL) max_total_ff <= csr_wdata;
         if (csr_addr == REG_MAX_COUNT) max_count_ff <= csr_wdata[15:0];
         if (csr_addr == REG_MAX_BYTES) max_bytes_ff <= csr_wdata[14:0];
      end
   end

   // header checks, all in parallel; signed fields must be non-negative
   assign sender_ok = (32'(sender) < SENDERS);
   assign total_ok  = !declared_total[31] && (declared_total != 32'd0) &&
                      (declared_total[31:24] == 8'd0) &&
                      (declared_total[23:0] <= max_total_ff);
   assign count_ok  = !chunk_count[31] && (chunk_count != 32'd0) &&
                      (chunk_count[31:16] == 16'd0) &&
                      (chunk_count[15:0] <= max_count_ff);
   assign index_ok  = !chunk_index[31] && (chunk_index < chunk_count);
   assign length_ok = !chunk_length[31] && (chunk_length[31:15] == 17'd0) &&
                      (chunk_length[14:0] <= max_bytes_ff) &&
                      (chunk_length[14:0] <= bytes_left);
   assign header_ok = sender_ok && !header_bad && total_ok && count_ok &&
                      index_ok && length_ok;

   // command build
   always_comb begin
      cmd.sender = sender;
      cmd.total  = declared_total[23:0];
      cmd.index  = chunk_index[15:0];
      cmd.count  = chunk_count[15:0];
      cmd.length = chunk_length[14:0];
      unique case (action)
         ACT_CHUNK: cmd.kind = header_ok ? K_CHUNK : K_BAD;
         ACT_CLEAR: cmd.kind = sender_ok ? K_CLEAR : K_NOP;
         ACT_FLUSH: cmd.kind = K_FLUSH;
         default:   cmd.kind = K_BAD;
      endcase
   end

endmodule

/* hdl/crt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_queue: command queue
// Short FIFO between classifier and context engine so each side can stall
// on its own.
// ----------------------------------------------------------------------------
module crt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  crt_pkg::crt_cmd_type push_cmd,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output crt_pkg::crt_cmd_type pop_cmd
);
   import crt_pkg::*;

   crt_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* hdl/crt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_back: context engine
// Per-sender context table with one read-modify-write per command, and the
// response register.
// ----------------------------------------------------------------------------
module crt_back #(
   parameter int SENDERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  crt_pkg::crt_cmd_type cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [23:0]          rsp_offset,
   output logic [23:0]          rsp_length
);
   import crt_pkg::*;

   // the sender field reaches at most sixteen contexts
   localparam int DEPTH = (SENDERS > 16) ? 16 : SENDERS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [23:0]      total_ff [DEPTH];
   logic [15:0]      next_ff  [DEPTH];
   logic [23:0]      recv_ff  [DEPTH];

   logic             rsp_valid_ff;
   logic [2:0]       status_ff;
   logic [23:0]      offset_ff;
   logic [23:0]      length_ff;
   logic [2:0]       status_in;
   logic [23:0]      offset_in;
   logic [23:0]      length_in;

   logic [IDX_W-1:0] idx;
   logic             take;
   logic             restart;
   logic [15:0]      next_cur;
   logic [23:0]      base;
   logic [24:0]      recv_sum;
   logic             last;
   logic             ctx_write;

   assign take      = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign idx       = cmd.sender[IDX_W-1:0];

   // context lookup; a restart starts from an empty context
   assign restart  = (cmd.index == 16'd0) || !valid_ff[idx] ||
                     (total_ff[idx] != cmd.total);
   assign next_cur = restart ? 16'd0 : next_ff[idx];
   assign base     = restart ? 24'd0 : recv_ff[idx];
   assign recv_sum = {1'b0, base} + 25'(cmd.length);
   assign last     = ({1'b0, cmd.index} + 17'd1) >= {1'b0, cmd.count};

   // result and context update
   always_comb begin
      valid_in  = valid_ff;
      ctx_write = 1'b0;
      status_in = ST_CLEARED;
      offset_in = 24'd0;
      length_in = 24'd0;
      unique case (cmd.kind)
         K_CHUNK: begin
            if (next_cur != cmd.index) begin
               status_in     = ST_ORDER;
               valid_in[idx] = 1'b0;
            end else if (recv_sum > {1'b0, cmd.total}) begin
               status_in     = ST_OVERFLOW;
               valid_in[idx] = 1'b0;
            end else if (!last) begin
               status_in     = ST_PARTIAL;
               offset_in     = base;
               valid_in[idx] = 1'b1;
               ctx_write     = 1'b1;
            end else begin
               valid_in[idx] = 1'b0;
               if (recv_sum != {1'b0, cmd.total}) begin
                  status_in = ST_MISMATCH;
               end else begin
                  status_in = ST_COMPLETE;
                  offset_in = base;
                  length_in = cmd.total;
               end
            end
         end
         K_BAD:   status_in = ST_BADHDR;
         K_CLEAR: valid_in[idx] = 1'b0;
         K_FLUSH: valid_in = '0;
         K_NOP:   status_in = ST_CLEARED;
         default: status_in = ST_BADHDR;
      endcase
   end

   // valid bits and response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) valid_ff <= valid_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // context payload and response word
   always_ff @(posedge clock) begin
      if (take && ctx_write) begin
         total_ff[idx] <= cmd.total;
         next_ff[idx]  <= cmd.index + 16'd1;
         recv_ff[idx]  <= recv_sum[23:0];
      end
      if (take) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_offset = offset_ff;
   assign rsp_length = length_ff;

endmodule

/* hdl/chunk_reassembly_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker: in-order chunk reassembly, one context per sender
//
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tdata: sender, header fields; tuser: action, flag
//   rsp_     out  tvalid/tready      tdata: offset, length; tuser: status
//   csr_     in   we (no wait)       addr, wdata
//
// One word per cycle sustained while responses are taken. A request that is taken
// is classified on its way into a queue slot; the engine pops it from the queue and
// does the context read-modify-write into the response register, where the response
// word is held until taken. Reset clears all contexts and limits to their defaults;
// no clearing pass is needed. A stalled response holds the engine, the two-entry
// queue then fills and req_tready drops.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker #(
   parameter int SENDERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,   // sender, declared_total, chunk_index,
                                     // chunk_count, chunk_length, bytes_left
   input  logic [2:0]   req_tuser,   // action, header_bad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // write_offset, model_length
   output logic [2:0]   rsp_tuser,   // status
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [23:0]  csr_wdata
);
   import crt_pkg::*;

   crt_cmd_type front_cmd;
   crt_cmd_type queue_cmd;
   logic        queue_valid;
   logic        back_ready;
   logic [23:0] rsp_offset;
   logic [23:0] rsp_length;

   crt_front #(.SENDERS(SENDERS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .action         (req_tuser[1:0]),
      .sender         (req_tdata[3:0]),
      .declared_total (req_tdata[35:4]),
      .chunk_index    (req_tdata[67:36]),
      .chunk_count    (req_tdata[99:68]),
      .chunk_length   (req_tdata[131:100]),
      .bytes_left     (req_tdata[146:132]),
      .header_bad     (req_tuser[2]),
      .cmd            (front_cmd)
   );

   crt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (queue_cmd)
   );

   crt_back #(.SENDERS(SENDERS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (back_ready),
      .cmd        (queue_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_offset (rsp_offset),
      .rsp_length (rsp_length)
   );

   assign rsp_tdata = {rsp_length, rsp_offset};

endmodule

/* hdl/crt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_checker: port-level checks of the chunk reassembly tracker
// Watches the response channel for word consistency and holding under stall.
// ----------------------------------------------------------------------------
module crt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import crt_pkg::*;

   // no response right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // length only reported on completion
   a_length_on_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_COMPLETE)) |-> (rsp_tdata[47:24] == 24'd0))
      else $error("length set without completion");

   // offset only reported for accepted chunks, and never past the total
   a_offset_scope: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_PARTIAL) && (rsp_tuser != ST_COMPLETE))
      |-> (rsp_tdata[23:0] == 24'd0))
      else $error("offset set on a rejected word");

   a_offset_in_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_COMPLETE))
      |-> (rsp_tdata[23:0] <= rsp_tdata[47:24]))
      else $error("completion offset beyond total");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
      |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind chunk_reassembly_tracker crt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/chunk_reassembly_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker_tb: self-checking bench for the reassembly tracker
// Drives chunk headers, clears and flushes on the request stream. Each
// accepted word is run through a local context-table predictor, and every
// response word is checked against it in order. Limit registers are
// reprogrammed between phases while the block is idle. The random traffic
// interleaves well-formed transfers from all senders and mixes in broken
// transfers and noise. The sender pauses in bursts and the receiver stalls
// at random.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker_tb;
   import crt_pkg::*;

   localparam int         N_SENDERS  = 16;
   localparam int         PLAN_DEPTH = 16;
   localparam int         MAX_PRINTS = 200;
   localparam logic [1:0] ACT_UNUSED = 2'd3;   // action code with no meaning
   localparam logic [1:0] REG_UNUSED = 2'd3;   // index past the last register

   // one request word, unpacked into header fields
   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  sender;
      logic [31:0] total;
      logic [31:0] index;
      logic [31:0] count;
      logic [31:0] length;
      logic [14:0] left;
      logic        bad;
   } hdr_word_type;

   // one response word
   typedef struct packed {
      logic [2:0]  status;
      logic [23:0] offset;
      logic [23:0] tlen;
   } rsp_word_type;

   // -------------------------------------------------------------------------
   // context-table predictor and in-order response checker
   // -------------------------------------------------------------------------
   class reassembly_scoreboard;
      logic [23:0] lim_total;
      logic [15:0] lim_count;
      logic [14:0] lim_bytes;
      bit          ctx_open [N_SENDERS];
      logic [23:0] ctx_total[N_SENDERS];
      logic [15:0] ctx_next [N_SENDERS];
      logic [23:0] ctx_rcvd [N_SENDERS];
      rsp_word_type expected_q[$];
      int          errors;

      function new();
         lim_total = MAX_TOTAL_RST;
         lim_count = MAX_COUNT_RST;
         lim_bytes = MAX_BYTES_RST;
         foreach (ctx_open[i]) begin
            ctx_open[i]  = 1'b0;
            ctx_total[i] = '0;
            ctx_next[i]  = '0;
            ctx_rcvd[i]  = '0;
         end
         errors = 0;
      endfunction

      function void write_limit(logic [1:0] addr, logic [23:0] val);
         case (addr)
            REG_MAX_TOTAL: lim_total = val;
            REG_MAX_COUNT: lim_count = val[15:0];
            REG_MAX_BYTES: lim_bytes = val[14:0];
            default: ;
         endcase
      endfunction

      // next response for one request word; updates the context table
      function rsp_word_type track(hdr_word_type w);
         longint    tot, idx, cnt, len, sum;
         int        s;
         logic [23:0] start;
         rsp_word_type r;
         tot = longint'($signed(w.total));
         idx = longint'($signed(w.index));
         cnt = longint'($signed(w.count));
         len = longint'($signed(w.length));
         s = int'(w.sender);
         r = '0;
         r.status = ST_BADHDR;

         if (w.action == ACT_FLUSH) begin
            foreach (ctx_open[i]) ctx_open[i] = 1'b0;
            r.status = ST_CLEARED;
            return r;
         end
         if (w.action == ACT_CLEAR) begin
            if (s < N_SENDERS) ctx_open[s] = 1'b0;
            r.status = ST_CLEARED;
            return r;
         end

         // header limit checks, no state change on failure
         if (w.action != ACT_CHUNK || s >= N_SENDERS || w.bad) return r;
         if (tot <= 0 || tot > longint'(lim_total)) return r;
         if (cnt <= 0 || cnt > longint'(lim_count)) return r;
         if (idx < 0 || idx >= cnt) return r;
         if (len < 0 || len > longint'(lim_bytes) || len > longint'(w.left)) return r;

         // restart on first chunk, closed context or changed total
         if (idx == 0 || !ctx_open[s] || longint'(ctx_total[s]) != tot) begin
            ctx_open[s]  = 1'b1;
            ctx_total[s] = tot[23:0];
            ctx_next[s]  = '0;
            ctx_rcvd[s]  = '0;
         end
         if (longint'(ctx_next[s]) != idx) begin
            ctx_open[s] = 1'b0;
            r.status = ST_ORDER;
            return r;
         end
         start = ctx_rcvd[s];
         sum = longint'(start) + len;
         if (sum > tot) begin
            ctx_open[s] = 1'b0;
            r.status = ST_OVERFLOW;
            return r;
         end
         if (longint'(ctx_next[s]) + 1 < cnt) begin
            ctx_next[s] = ctx_next[s] + 16'd1;
            ctx_rcvd[s] = sum[23:0];
            r.status = ST_PARTIAL;
            r.offset = start;
            return r;
         end
         // last chunk closes the context either way
         ctx_open[s] = 1'b0;
         if (sum != tot) begin
            r.status = ST_MISMATCH;
            return r;
         end
         r.status = ST_COMPLETE;
         r.offset = start;
         r.tlen   = tot[23:0];
         return r;
      endfunction

      function void note_request(hdr_word_type w);
         expected_q.insert(expected_q.size(), track(w));
      endfunction

      function void flag(string what, longint exp_v, longint act_v);
         errors++;
         if (errors <= MAX_PRINTS)
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, exp_v, act_v);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type exp_w;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_PRINTS)
               $display("%0t: unexpected response: expected none actual status %0d",
                        $time, got.status);
            return;
         end
         exp_w = expected_q.pop_front();
         if (got.status !== exp_w.status) flag("status", exp_w.status, got.status);
         if (got.offset !== exp_w.offset) flag("write_offset", exp_w.offset, got.offset);
         if (got.tlen !== exp_w.tlen) flag("model_length", exp_w.tlen, got.tlen);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and DUT
   // -------------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;   // sender, declared_total, chunk_index,
                                   // chunk_count, chunk_length, bytes_left
   logic [2:0]   req_tuser = '0;   // action, header_bad
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;        // write_offset, model_length
   logic [2:0]   rsp_tuser;        // status
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [23:0]  csr_wdata = '0;

   reassembly_scoreboard sb;

   // sender and receiver pacing
   int burst_left = 0;
   bit gaps_on    = 1'b1;
   bit stalls_on  = 1'b1;
   int rx_hold    = 0;

   // per-sender transfer plans for the random part
   hdr_word_type plan[N_SENDERS][PLAN_DEPTH];
   int        plan_len[N_SENDERS];
   int        plan_pos[N_SENDERS];

   chunk_reassembly_tracker #(.SENDERS(N_SENDERS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver backpressure: random stalls when enabled
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready = 1'b0;
         rx_hold--;
      end else begin
         rsp_tready = 1'b1;
         if (stalls_on && $urandom_range(0, 99) < 20) rx_hold = $urandom_range(1, 6);
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.offset = rsp_tdata[23:0];
         got.tlen   = rsp_tdata[47:24];
         sb.check_response(got);
      end
   end

   // -------------------------------------------------------------------------
   // word builders
   // -------------------------------------------------------------------------
   function automatic hdr_word_type chunk(int s, logic [31:0] total, logic [31:0] idx,
                                          logic [31:0] cnt, logic [31:0] len,
                                          logic [14:0] left);
      hdr_word_type w;
      w.action = ACT_CHUNK;
      w.sender = s[3:0];
      w.total  = total;
      w.index  = idx;
      w.count  = cnt;
      w.length = len;
      w.left   = left;
      w.bad    = 1'b0;
      return w;
   endfunction

   function automatic hdr_word_type control(logic [1:0] act, int s);
      hdr_word_type w;
      w = chunk(s, $urandom, $urandom, $urandom, $urandom,
                15'($urandom_range(0, 32767)));
      w.action = act;
      w.bad    = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // noise: controls, unused action, raw random headers, near-valid headers
   function automatic hdr_word_type make_noise();
      hdr_word_type w;
      int        pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0: w = control(ACT_FLUSH, $urandom_range(0, 15));
         1: w = control(ACT_CLEAR, $urandom_range(0, 15));
         2: w = control(ACT_UNUSED, $urandom_range(0, 15));
         3: begin
            w = control(ACT_CHUNK, $urandom_range(0, 15));
         end
         4: begin
            w = chunk($urandom_range(0, 15), $urandom_range(1, 3000), 0,
                      $urandom_range(1, 4), $urandom_range(0, 500), 15'd32767);
            w.bad = 1'b1;
         end
         default: begin
            w = chunk($urandom_range(0, 15), $urandom_range(1, 4000),
                      $urandom_range(0, 5), $urandom_range(1, 6),
                      $urandom_range(0, 1500), 15'($urandom_range(0, 32767)));
         end
      endcase
      return w;
   endfunction

   // one transfer for sender s, sometimes broken on purpose
   task automatic build_transfer(int s);
      int          cnt, cap, m, n, i, j, tmp;
      longint      sum, total;
      int          lens[PLAN_DEPTH];
      int          order[PLAN_DEPTH];
      logic [14:0] left;
      cnt = $urandom_range(1, (sb.lim_count < 12) ? int'(sb.lim_count) : 12);
      cap = (sb.lim_bytes < 3000) ? int'(sb.lim_bytes) :
            (($urandom_range(0, 3) == 0) ? int'(sb.lim_bytes) : 3000);
      sum = 0;
      for (i = 0; i < cnt; i++) begin
         lens[i] = $urandom_range(0, cap);
         sum += lens[i];
      end
      if (sum == 0) begin
         lens[0] = 1;
         sum = 1;
      end
      total = sum;
      for (i = 0; i < cnt; i++) order[i] = i;
      n = cnt;
      m = $urandom_range(0, 99);
      if (m < 4) begin
         total = sum + $urandom_range(1, 50);            // short by the end
      end else if (m < 8 && sum > 1) begin
         total = sum - 1;                                // runs past the total
      end else if (m < 11 && cnt > 1) begin
         i = $urandom_range(0, cnt - 2);                 // two chunks swapped
         tmp = order[i];
         order[i] = order[i + 1];
         order[i + 1] = tmp;
      end else if (m < 14 && cnt > 2) begin
         i = $urandom_range(1, cnt - 2);                 // one chunk lost
         for (j = i; j < cnt - 1; j++) order[j] = order[j + 1];
         n = cnt - 1;
      end else if (m < 16) begin
         i = $urandom_range(0, cnt - 1);                 // one chunk repeated
         for (j = cnt; j > i; j--) order[j] = order[j - 1];
         n = cnt + 1;
      end
      for (i = 0; i < n; i++) begin
         j = order[i];
         if ($urandom_range(0, 9) == 0)
            left = 15'($urandom_range(lens[j], 32767));
         else
            left = (lens[j] + 64 > 32767) ? 15'd32767 :
                   15'(lens[j] + $urandom_range(0, 64));
         plan[s][i] = chunk(s, total[31:0], j, cnt, lens[j], left);
         if ($urandom_range(0, 199) == 0) plan[s][i].left = 15'(lens[j] - 1);
      end
      plan_len[s] = n;
      plan_pos[s] = 0;
   endtask

   // -------------------------------------------------------------------------
   // driver tasks
   // -------------------------------------------------------------------------
   task automatic send_word(hdr_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {5'd0, w.left, w.length, w.count, w.index, w.total, w.sender};
      req_tuser  = {w.bad, w.action};
      do @(posedge clock); while (!req_tready);
      sb.note_request(w);
   endtask

   // hold off until every response is back, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] addr, logic [23:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_limit(addr, val);
   endtask

   task automatic set_limits(logic [23:0] tot, logic [23:0] cnt, logic [23:0] bytes);
      wait_drained();
      write_reg(REG_MAX_TOTAL, tot);
      write_reg(REG_MAX_COUNT, cnt);
      write_reg(REG_MAX_BYTES, bytes);
   endtask

   // interleaved transfers from all senders plus noise
   task automatic run_random(int n_items);
      int sent, s;
      sent = 0;
      while (sent < n_items) begin
         for (s = 0; s < N_SENDERS; s++) begin
            if (plan_pos[s] >= plan_len[s] && $urandom_range(0, 3) == 0)
               build_transfer(s);
            else if (plan_pos[s] < plan_len[s] && $urandom_range(0, 299) == 0)
               build_transfer(s);   // abandon mid-transfer, restart at index zero
         end
         s = $urandom_range(0, N_SENDERS - 1);
         if ($urandom_range(0, 99) < 8) begin
            send_word(make_noise());
            sent++;
         end else if (plan_pos[s] < plan_len[s]) begin
            send_word(plan[s][plan_pos[s]]);
            plan_pos[s]++;
            sent++;
         end else begin
            continue;
         end
         if (sent % 150 == 0) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
         end
         if (sent % 500 == 0) wait_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      foreach (plan_len[i]) begin
         plan_len[i] = 0;
         plan_pos[i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed checks at reset limits
      send_word(control(ACT_FLUSH, 0));
      send_word(control(ACT_CLEAR, 15));
      send_word(control(ACT_UNUSED, 9));
      begin
         hdr_word_type w;
         w = chunk(1, 100, 0, 1, 100, 100);
         w.bad = 1'b1;
         send_word(w);                                       // parse failure flag
      end
      send_word(chunk(1, 0, 0, 1, 0, 0));                    // zero total
      send_word(chunk(1, 32'h8000_0000, 0, 1, 0, 0));        // negative total
      send_word(chunk(1, 1048577, 0, 1, 0, 0));              // total over limit
      send_word(chunk(1, 100, 0, 0, 0, 0));                  // zero count
      send_word(chunk(1, 100, 0, 257, 0, 0));                // count over limit
      send_word(chunk(1, 100, 32'hFFFF_FFFF, 2, 0, 0));      // negative index
      send_word(chunk(1, 100, 2, 2, 0, 0));                  // index past count
      send_word(chunk(1, 100, 0, 2, 32'h8000_0000, 0));      // negative length
      send_word(chunk(1, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 8001, 15'd32767));
      send_word(chunk(1, 100, 0, 2, 50, 49));                // length over bytes left
      send_word(chunk(3, 300, 0, 3, 100, 15'd32767));        // clean three-chunk run
      send_word(chunk(3, 300, 1, 3, 100, 100));
      send_word(chunk(3, 300, 2, 3, 100, 100));
      send_word(chunk(4, 50, 0, 2, 20, 20));
      send_word(chunk(4, 50, 1, 2, 31, 31));                 // overflow
      send_word(chunk(5, 50, 0, 2, 20, 20));
      send_word(chunk(5, 50, 1, 2, 20, 20));                 // short at the end
      send_word(chunk(6, 80, 1, 2, 10, 10));                 // no open context
      send_word(chunk(7, 100, 0, 2, 10, 10));
      send_word(chunk(7, 200, 1, 2, 10, 10));                // total changed mid-run
      send_word(chunk(8, 1, 0, 1, 1, 1));                    // single-chunk transfer

      // lowest legal limits
      set_limits(24'd1, 24'd1, 24'd0);
      send_word(chunk(2, 1, 0, 1, 0, 0));
      send_word(chunk(2, 2, 0, 1, 0, 0));
      send_word(chunk(2, 1, 0, 1, 1, 1));
      send_word(chunk(2, 1, 0, 2, 0, 0));

      // zero limits block every chunk; a write past the last register is ignored
      set_limits(24'd0, 24'd0, 24'd0);
      write_reg(REG_UNUSED, 24'hFFFFFF);
      send_word(chunk(2, 1, 0, 1, 0, 0));
      send_word(chunk(2, 5, 0, 1, 0, 0));

      // random phases: reset values, largest limits, tight limits
      set_limits(MAX_TOTAL_RST, 24'(MAX_COUNT_RST), 24'(MAX_BYTES_RST));
      run_random(700);
      set_limits(24'hFFFFFF, 24'hFFFF, 24'h7FFF);
      run_random(600);
      set_limits(24'd20000, 24'd8, 24'd1500);
      run_random(600);

      // drain and settle
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("chunk_reassembly_tracker test passed");
      else
         $display("chunk_reassembly_tracker test failed");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("chunk_reassembly_tracker test failed");
      $finish;
   end

endmodule
